@@ rtl/scoru_pkg.sv @@
// Shared types, widths and helpers for the segment chain orienter.
// No dependencies; every other file in rtl/ imports this package.
package scoru_pkg;

	localparam int COORD_BITS   = 24;
	localparam int COUNT_BITS   = 11;
	localparam int MAX_SEGMENTS = 1024;
	localparam int TOL_BITS     = 16;
	localparam int TOL_SQ_BITS  = 2 * TOL_BITS;
	localparam int DIST_BITS    = 2 * COORD_BITS + 1;

	localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(50);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DIST_BITS-1:0]         dist_t;
	typedef logic [COUNT_BITS-1:0]        count_t;
	typedef logic [TOL_BITS-1:0]          tol_t;
	typedef logic [TOL_SQ_BITS-1:0]       tol_sq_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		point_t a;
		point_t b;
	} seg_t;

	typedef struct packed {
		logic   seg_valid;
		seg_t   seg;
		logic   rev;
		logic   mis;
		count_t deg_cnt;
		count_t rev_cnt;
		count_t mis_cnt;
		logic   eoc;
	} res_t;

	// saturating tally increment
	function automatic count_t bump(input count_t c);
		count_t r;
		r = c;
		if (c < COUNT_BITS'(MAX_SEGMENTS)) begin
			r = c + count_t'(1);
		end
		return r;
	endfunction

	function automatic seg_t orient(input seg_t s, input logic swap);
		seg_t r;
		r = s;
		if (swap) begin
			r.a = s.b;
			r.b = s.a;
		end
		return r;
	endfunction

endpackage

@@ rtl/scoru_dist.sv @@
// Exact squared Euclidean distance between two points.
// Depends on scoru_pkg for point and distance types.
module scoru_dist (
	input  scoru_pkg::point_t p,
	input  scoru_pkg::point_t q,
	output scoru_pkg::dist_t  d
);
	import scoru_pkg::*;

	logic [COORD_BITS:0]     dx, dy, ndx, ndy;
	logic [COORD_BITS-1:0]   mx, my;
	logic [2*COORD_BITS-1:0] sx, sy;

	assign dx  = {q.x[COORD_BITS-1], q.x} - {p.x[COORD_BITS-1], p.x};
	assign dy  = {q.y[COORD_BITS-1], q.y} - {p.y[COORD_BITS-1], p.y};
	assign ndx = -dx;
	assign ndy = -dy;

	// the magnitude of a difference of two coordinates always fits in COORD_BITS unsigned bits
	assign mx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
	assign my = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

	assign sx = (2*COORD_BITS)'(mx) * (2*COORD_BITS)'(mx);
	assign sy = (2*COORD_BITS)'(my) * (2*COORD_BITS)'(my);
	assign d  = {1'b0, sx} + {1'b0, sy};

endmodule

@@ rtl/segment_chain_orienter_unit.sv @@
// Top level of the segment chain orienter: input register, distance stage,
// decision stage and result register. Depends on scoru_pkg and scoru_dist.
//
// Usage:
//  - Input channel in_valid/in_stall carries one segment per request plus
//    last_segment. A request is taken when in_valid is high and in_stall low.
//  - Output channel out_valid/out_stall carries the results of the requests.
//  - cfg_valid/cfg_ready writes link_tolerance; cfg_ready is always high.
//    Write only while the block is idle.
//  - A chain's first segment and a degenerate one give a result only when
//    last; the segment that closes the first link gives two, the held one's
//    result first; any other gives one. A segment passes the input register
//    and the decision stage to the result register. Through the chain state
//    loop, distances are formed only after the previous decision updates the
//    held segment and previous end; the input register can hold the next.
//  - Reset clears the chain to empty, the tallies to zero and the tolerance
//    to 50 mm. No clearing pass is needed.
//  - While out_stall is high the result register holds; the decision stage
//    and then the input register fill, and in_stall rises.
module segment_chain_orienter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  scoru_pkg::coord_t   start_x,
	input  scoru_pkg::coord_t   start_y,
	input  scoru_pkg::coord_t   end_x,
	input  scoru_pkg::coord_t   end_y,
	input  logic                last_segment,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  scoru_pkg::tol_t     cfg_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                seg_valid,
	output scoru_pkg::coord_t   out_start_x,
	output scoru_pkg::coord_t   out_start_y,
	output scoru_pkg::coord_t   out_end_x,
	output scoru_pkg::coord_t   out_end_y,
	output logic                was_reversed,
	output logic                link_mismatch,
	output scoru_pkg::count_t   degenerate_count,
	output scoru_pkg::count_t   reversed_count,
	output scoru_pkg::count_t   mismatch_count,
	output logic                end_of_chain
);
	import scoru_pkg::*;

	localparam logic [1:0] MODE_EMPTY = 2'd0;
	localparam logic [1:0] MODE_HELD  = 2'd1;
	localparam logic [1:0] MODE_RUN   = 2'd2;

	// chain state
	logic [1:0] mode_q;
	seg_t       hold_q;
	point_t     prev_q;
	count_t     deg_q, rev_q, mis_q;
	tol_sq_t    tol_sq_q;

	// input register
	logic s1_valid;
	seg_t seg_s1;
	logic last_s1;

	// decision stage
	logic  s2_valid, phase_s2, degen_s2, last_s2;
	seg_t  seg_s2;
	dist_t d00_s2, d01_s2, d10_s2, d11_s2;

	// result register
	logic out_valid_q;
	res_t res_q;

	logic   accept, transfer, out_ok, emit, commit;
	logic   has_res, two, final_res;
	point_t ref1;
	dist_t  d00, d01, d10, d11, tol_sq;
	logic   t00, t01, t10, t11, fb, lt01, lt11;
	logic   rev_h, mis_h, use_r0, rev_n, mis_n;
	logic   rev_h_bump, mis_h_bump, rev_n_bump, mis_n_bump;
	count_t deg_n, rev1c, mis1c, rev2c, mis2c;
	res_t   res_first, res_last, res_sel;

	assign cfg_ready = 1'b1;

	assign in_stall = s1_valid && s2_valid;
	assign accept   = in_valid && !in_stall;
	// s2 must be empty so the distances see the settled chain state
	assign transfer = s1_valid && !s2_valid;

	// reference points: held start and held end, or the previous end when running
	assign ref1 = (mode_q == MODE_HELD) ? hold_q.b : prev_q;

	scoru_dist u_d00 (.p(hold_q.a), .q(seg_s1.a), .d(d00));
	scoru_dist u_d01 (.p(hold_q.a), .q(seg_s1.b), .d(d01));
	scoru_dist u_d10 (.p(ref1),     .q(seg_s1.a), .d(d10));
	scoru_dist u_d11 (.p(ref1),     .q(seg_s1.b), .d(d11));

	assign tol_sq = DIST_BITS'(tol_sq_q);
	assign t00  = d00_s2 <= tol_sq;
	assign t01  = d01_s2 <= tol_sq;
	assign t10  = d10_s2 <= tol_sq;
	assign t11  = d11_s2 <= tol_sq;
	assign lt01 = d01_s2 < d00_s2;
	assign lt11 = d11_s2 < d10_s2;

	// min(a0a1, a0b1) < min(b0a1, b0b1), written as parallel compares
	assign fb = ((d00_s2 < d10_s2) && (d00_s2 < d11_s2)) ||
	            ((d01_s2 < d10_s2) && (d01_s2 < d11_s2));

	always_comb begin
		if (t10) begin
			rev_h = 1'b0;
		end else if (t00) begin
			rev_h = 1'b1;
		end else if (t11) begin
			rev_h = 1'b0;
		end else if (t01) begin
			rev_h = 1'b1;
		end else begin
			rev_h = fb;
		end
	end
	assign mis_h = !(t10 || t00 || t11 || t01);

	// the new segment links to the held start if the held one was reversed
	assign use_r0 = (mode_q == MODE_HELD) && rev_h;
	assign rev_n  = use_r0 ? lt01 : lt11;
	assign mis_n  = use_r0 ? !(rev_n ? t01 : t00) : !(rev_n ? t11 : t10);

	assign two       = !degen_s2 && (mode_q == MODE_HELD);
	assign has_res   = last_s2 || (!degen_s2 && (mode_q != MODE_EMPTY));
	assign final_res = !two || phase_s2;

	assign rev_h_bump = two && rev_h;
	assign mis_h_bump = two && mis_h;
	assign rev_n_bump = !degen_s2 && (mode_q != MODE_EMPTY) && rev_n;
	assign mis_n_bump = !degen_s2 && (mode_q != MODE_EMPTY) && mis_n;

	assign deg_n = degen_s2 ? bump(deg_q) : deg_q;
	assign rev1c = rev_h_bump ? bump(rev_q) : rev_q;
	assign mis1c = mis_h_bump ? bump(mis_q) : mis_q;
	assign rev2c = rev_n_bump ? bump(rev1c) : rev1c;
	assign mis2c = mis_n_bump ? bump(mis1c) : mis1c;

	always_comb begin
		res_first.seg_valid = 1'b1;
		res_first.seg       = orient(hold_q, rev_h);
		res_first.rev       = rev_h;
		res_first.mis       = mis_h;
		res_first.deg_cnt   = deg_n;
		res_first.rev_cnt   = rev1c;
		res_first.mis_cnt   = mis1c;
		res_first.eoc       = 1'b0;

		res_last.seg_valid = 1'b1;
		res_last.seg       = orient(seg_s2, rev_n);
		res_last.rev       = rev_n;
		res_last.mis       = mis_n;
		res_last.deg_cnt   = deg_n;
		res_last.rev_cnt   = rev2c;
		res_last.mis_cnt   = mis2c;
		res_last.eoc       = last_s2;
		if (degen_s2) begin
			// only reached on the last segment
			res_last.rev = 1'b0;
			res_last.mis = 1'b0;
			res_last.eoc = 1'b1;
			if (mode_q == MODE_HELD) begin
				res_last.seg = hold_q;
			end else begin
				res_last.seg_valid = 1'b0;
				res_last.seg       = '0;
			end
		end else begin
			case (mode_q)
				MODE_EMPTY: begin
					// lone first segment closing the chain
					res_last.seg = seg_s2;
					res_last.rev = 1'b0;
					res_last.mis = 1'b0;
					res_last.eoc = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign res_sel = (two && !phase_s2) ? res_first : res_last;

	assign out_ok = !out_valid_q || !out_stall;
	assign emit   = s2_valid && has_res && out_ok;
	assign commit = s2_valid && (!has_res || (out_ok && final_res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			phase_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_EMPTY;
			deg_q       <= '0;
			rev_q       <= '0;
			mis_q       <= '0;
			tol_sq_q    <= TOL_SQ_BITS'(TOL_RESET * TOL_RESET);
		end else begin
			if (cfg_valid && cfg_ready) begin
				tol_sq_q <= TOL_SQ_BITS'(cfg_data) * TOL_SQ_BITS'(cfg_data);
			end

			if (accept) begin
				s1_valid <= 1'b1;
			end else if (transfer) begin
				s1_valid <= 1'b0;
			end

			if (transfer) begin
				s2_valid <= 1'b1;
			end else if (commit) begin
				s2_valid <= 1'b0;
			end

			if (commit) begin
				phase_s2 <= 1'b0;
			end else if (emit && two) begin
				phase_s2 <= 1'b1;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (commit) begin
				if (last_s2) begin
					mode_q <= MODE_EMPTY;
					deg_q  <= '0;
					rev_q  <= '0;
					mis_q  <= '0;
				end else begin
					deg_q <= deg_n;
					rev_q <= rev2c;
					mis_q <= mis2c;
					if (!degen_s2) begin
						mode_q <= (mode_q == MODE_EMPTY) ? MODE_HELD : MODE_RUN;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			seg_s1.a.x <= start_x;
			seg_s1.a.y <= start_y;
			seg_s1.b.x <= end_x;
			seg_s1.b.y <= end_y;
			last_s1    <= last_segment;
		end
		if (transfer) begin
			seg_s2   <= seg_s1;
			last_s2  <= last_s1;
			degen_s2 <= (seg_s1.a == seg_s1.b);
			d00_s2   <= d00;
			d01_s2   <= d01;
			d10_s2   <= d10;
			d11_s2   <= d11;
		end
		if (commit && !degen_s2) begin
			if (mode_q == MODE_EMPTY) begin
				hold_q <= seg_s2;
			end else begin
				prev_q <= rev_n ? seg_s2.a : seg_s2.b;
			end
		end
		if (emit) begin
			res_q <= res_sel;
		end
	end

	assign out_valid        = out_valid_q;
	assign seg_valid        = res_q.seg_valid;
	assign out_start_x      = res_q.seg.a.x;
	assign out_start_y      = res_q.seg.a.y;
	assign out_end_x        = res_q.seg.b.x;
	assign out_end_y        = res_q.seg.b.y;
	assign was_reversed     = res_q.rev;
	assign link_mismatch    = res_q.mis;
	assign degenerate_count = res_q.deg_cnt;
	assign reversed_count   = res_q.rev_cnt;
	assign mismatch_count   = res_q.mis_cnt;
	assign end_of_chain     = res_q.eoc;

endmodule

@@ sim/segment_chain_orienter_unit_tb.sv @@
// Self-checking testbench for segment_chain_orienter_unit: directed chains,
// output back-pressure and random chains, scored against a local predictor.
// Depends on rtl/scoru_pkg.sv and rtl/segment_chain_orienter_unit.sv.
module segment_chain_orienter_unit_tb;
	import scoru_pkg::*;

	typedef enum logic [1:0] {CHAIN_EMPTY, CHAIN_HELD, CHAIN_LINKED} chain_state_e;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t start_x = '0;
	coord_t start_y = '0;
	coord_t end_x = '0;
	coord_t end_y = '0;
	logic   last_segment = 1'b0;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	tol_t   cfg_data = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic   seg_valid;
	coord_t out_start_x, out_start_y, out_end_x, out_end_y;
	logic   was_reversed, link_mismatch, end_of_chain;
	count_t degenerate_count, reversed_count, mismatch_count;

	// predictor state
	chain_state_e chain_state = CHAIN_EMPTY;
	seg_t         held_seg;
	point_t       chain_tip;
	count_t       n_degenerate = '0;
	count_t       n_reversed = '0;
	count_t       n_mismatch = '0;
	tol_t         link_tol = TOL_RESET;
	res_t         oriented_due[$];

	int errors = 0;
	bit quiet = 1'b1;
	int stall_hold = 0;

	segment_chain_orienter_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.start_x          (start_x),
		.start_y          (start_y),
		.end_x            (end_x),
		.end_y            (end_y),
		.last_segment     (last_segment),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.seg_valid        (seg_valid),
		.out_start_x      (out_start_x),
		.out_start_y      (out_start_y),
		.out_end_x        (out_end_x),
		.out_end_y        (out_end_y),
		.was_reversed     (was_reversed),
		.link_mismatch    (link_mismatch),
		.degenerate_count (degenerate_count),
		.reversed_count   (reversed_count),
		.mismatch_count   (mismatch_count),
		.end_of_chain     (end_of_chain)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic count_t sat_inc(input count_t c);
		return (c < count_t'(MAX_SEGMENTS)) ? c + count_t'(1) : c;
	endfunction

	// exact squared distance, wide enough for opposite corners of the coordinate range
	function automatic longint unsigned gap2(input point_t p, input point_t q);
		longint px, py, qx, qy;
		px = p.x;
		py = p.y;
		qx = q.x;
		qy = q.y;
		return (qx - px) * (qx - px) + (qy - py) * (qy - py);
	endfunction

	function automatic logic near(input longint unsigned d);
		longint unsigned t;
		t = link_tol;
		return d <= t * t;
	endfunction

	function automatic longint unsigned min2(input longint unsigned a,
			input longint unsigned b);
		return (b < a) ? b : a;
	endfunction

	// orient one segment, update tallies and the chain tip
	function automatic res_t link_result(input seg_t s, input logic flip, input logic miss);
		res_t r;
		r = '0;
		r.seg_valid = 1'b1;
		r.seg.a = flip ? s.b : s.a;
		r.seg.b = flip ? s.a : s.b;
		r.rev = flip;
		r.mis = miss;
		if (flip)
			n_reversed = sat_inc(n_reversed);
		if (miss)
			n_mismatch = sat_inc(n_mismatch);
		r.deg_cnt = n_degenerate;
		r.rev_cnt = n_reversed;
		r.mis_cnt = n_mismatch;
		chain_tip = r.seg.b;
		return r;
	endfunction

	task automatic chain_step(input coord_t sx, input coord_t sy, input coord_t ex,
			input coord_t ey, input logic is_last);
		seg_t s;
		res_t outs[2];
		int n;
		logic flip, miss;
		longint unsigned a0a1, a0b1, b0a1, b0b1, da, db;
		s.a.x = sx;
		s.a.y = sy;
		s.b.x = ex;
		s.b.y = ey;
		n = 0;
		if (sx == ex && sy == ey) begin
			n_degenerate = sat_inc(n_degenerate);
		end else if (chain_state == CHAIN_EMPTY) begin
			held_seg = s;
			chain_state = CHAIN_HELD;
		end else begin
			if (chain_state == CHAIN_HELD) begin
				a0a1 = gap2(held_seg.a, s.a);
				a0b1 = gap2(held_seg.a, s.b);
				b0a1 = gap2(held_seg.b, s.a);
				b0b1 = gap2(held_seg.b, s.b);
				miss = 1'b0;
				if (near(b0a1))
					flip = 1'b0;
				else if (near(a0a1))
					flip = 1'b1;
				else if (near(b0b1))
					flip = 1'b0;
				else if (near(a0b1))
					flip = 1'b1;
				else begin
					flip = min2(a0a1, a0b1) < min2(b0a1, b0b1);
					miss = 1'b1;
				end
				outs[n] = link_result(held_seg, flip, miss);
				n++;
			end
			da = gap2(chain_tip, s.a);
			db = gap2(chain_tip, s.b);
			flip = db < da;
			miss = !near(flip ? db : da);
			outs[n] = link_result(s, flip, miss);
			n++;
			chain_state = CHAIN_LINKED;
		end
		if (is_last) begin
			if (chain_state == CHAIN_HELD || n == 0) begin
				// lone held segment goes out as given; otherwise an empty end marker
				outs[n] = '0;
				if (chain_state == CHAIN_HELD) begin
					outs[n].seg_valid = 1'b1;
					outs[n].seg = held_seg;
				end
				outs[n].deg_cnt = n_degenerate;
				outs[n].rev_cnt = n_reversed;
				outs[n].mis_cnt = n_mismatch;
				outs[n].eoc = 1'b1;
				n++;
			end else begin
				outs[n-1].eoc = 1'b1;
			end
			chain_state = CHAIN_EMPTY;
			n_degenerate = '0;
			n_reversed = '0;
			n_mismatch = '0;
		end
		for (int i = 0; i < n; i++)
			oriented_due.insert(oriented_due.size(), outs[i]);
	endtask

	function automatic void cmp_field(input string what, input longint want_v,
			input longint got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
			errors++;
		end
	endfunction

	task automatic check_result();
		res_t want;
		if (oriented_due.size() == 0) begin
			$display("%0t: unexpected result, expected none actual seg_valid=%0d eoc=%0d",
				$time, seg_valid, end_of_chain);
			errors++;
		end else begin
			want = oriented_due.pop_front();
			cmp_field("seg_valid", want.seg_valid, seg_valid);
			cmp_field("out_start_x", want.seg.a.x, out_start_x);
			cmp_field("out_start_y", want.seg.a.y, out_start_y);
			cmp_field("out_end_x", want.seg.b.x, out_end_x);
			cmp_field("out_end_y", want.seg.b.y, out_end_y);
			cmp_field("was_reversed", want.rev, was_reversed);
			cmp_field("link_mismatch", want.mis, link_mismatch);
			cmp_field("degenerate_count", want.deg_cnt, degenerate_count);
			cmp_field("reversed_count", want.rev_cnt, reversed_count);
			cmp_field("mismatch_count", want.mis_cnt, mismatch_count);
			cmp_field("end_of_chain", want.eoc, end_of_chain);
		end
	endtask

	// result side: check accepted results, then pick next cycle's stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
		if (stall_hold > 0) begin
			stall_hold--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 25);
		end
	end

	// called at a clock edge; returns at the edge where the request is taken
	task automatic send_segment(input coord_t sx, input coord_t sy, input coord_t ex,
			input coord_t ey, input logic is_last);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(99) < 25)
			gap = $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		last_segment <= is_last;
		do @(posedge clk); while (in_stall);
		chain_step(sx, sy, ex, ey, is_last);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (oriented_due.size() != 0)
			@(posedge clk);
		// degenerate segments leave no result, give the pipeline time to empty
		repeat (8) @(posedge clk);
	endtask

	task automatic write_tolerance(input tol_t v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		link_tol = v;
	endtask

	// a chain whose segments mostly start near the previous far end, in random direction
	task automatic send_linked_chain(input int len);
		int span, jit, tx, ty, ax, ay, bx, by;
		case ($urandom_range(3))
			0: span = 3;
			1: span = 200;
			2: span = 20000;
			default: span = 4000000;
		endcase
		tx = int'($urandom_range(16777215)) - 8388608;
		ty = int'($urandom_range(16777215)) - 8388608;
		for (int k = 0; k < len; k++) begin
			jit = ($urandom_range(4) == 0) ? int'(link_tol) + 60 : int'(link_tol) / 2;
			ax = tx + int'($urandom_range(2 * jit)) - jit;
			ay = ty + int'($urandom_range(2 * jit)) - jit;
			if ($urandom_range(19) == 0) begin
				bx = ax;
				by = ay;
			end else begin
				bx = ax + int'($urandom_range(2 * span)) - span;
				by = ay + int'($urandom_range(2 * span)) - span;
			end
			if ($urandom_range(1))
				send_segment(coord_t'(bx), coord_t'(by), coord_t'(ax), coord_t'(ay), k == len - 1);
			else
				send_segment(coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by), k == len - 1);
			tx = bx;
			ty = by;
		end
	endtask

	task automatic send_noise_item();
		coord_t x, y;
		x = coord_t'($urandom);
		y = coord_t'($urandom);
		if ($urandom_range(3) == 0)
			send_segment(x, y, x, y, $urandom_range(7) == 0);
		else
			send_segment(x, y, coord_t'($urandom), coord_t'($urandom), $urandom_range(7) == 0);
	endtask

	task automatic test_chain_ends();
		send_segment(1, 2, 3, 4, 1'b1);          // lone first segment
		send_segment(7, 7, 7, 7, 1'b1);          // end marker from empty chain
		send_segment(0, 0, 10, 0, 1'b0);
		send_segment(3, 3, 3, 3, 1'b1);          // held segment flushed by degenerate last
		send_segment(0, 0, 10, 0, 1'b0);
		send_segment(10, 0, 20, 0, 1'b0);
		send_segment(9, 9, 9, 9, 1'b1);          // end marker after a linked chain
	endtask

	task automatic test_endpoint_links();
		send_segment(0, 0, 1000, 0, 1'b0);       // far end meets next start
		send_segment(1010, 0, 2000, 0, 1'b1);
		send_segment(0, 0, 1000, 0, 1'b0);       // near end meets next start
		send_segment(-20, 0, -1000, 0, 1'b1);
		send_segment(0, 0, 1000, 0, 1'b0);       // far end meets next end
		send_segment(2000, 0, 1040, 0, 1'b1);
		send_segment(0, 0, 1000, 0, 1'b0);       // near end meets next end
		send_segment(-1000, 5, 0, 30, 1'b1);
		send_segment(0, 0, 10, 0, 1'b0);         // several tests pass, first one wins
		send_segment(20, 0, 30, 0, 1'b1);
	endtask

	task automatic test_fallback();
		write_tolerance(tol_t'(0));
		send_segment(0, 0, 1000, 0, 1'b0);       // nothing links, near end is closer
		send_segment(-5000, 0, -6000, 0, 1'b1);
		send_segment(0, 0, 1000, 0, 1'b0);       // fallback tie, then propagation ties
		send_segment(500, 3000, 500, -3000, 1'b0);
		send_segment(400, -3000, 600, -3000, 1'b1);
		send_segment(5, 5, 10, 10, 1'b0);        // exact link at zero tolerance
		send_segment(10, 10, 20, -3, 1'b1);
	endtask

	task automatic test_extremes();
		write_tolerance(tol_t'(16'hFFFF));
		send_segment(-8388608, -8388608, 8388607, 8388607, 1'b0);
		send_segment(8388607, 8388607, -8388608, 8388607, 1'b0);
		send_segment(8388607, -8388608, -8388608, 8388607, 1'b0);
		send_segment(-8388608, -8388608, -8388608, -8388608, 1'b0);
		send_segment(8388607, 8388607, 8388607, 8388607, 1'b1);
		send_segment(-8388608, 0, -8388600, 0, 1'b0);
		send_segment(8388607, 0, 8388000, 0, 1'b1);
	endtask

	task automatic test_back_pressure();
		write_tolerance(TOL_RESET);
		quiet = 1'b1;
		stall_hold = 80;
		send_linked_chain(30);
		settle();
	endtask

	task automatic test_random_chains();
		int done, len;
		tol_t t;
		done = 0;
		quiet = 1'b1;
		while (done < 840) begin
			if (done >= 250)
				quiet = 1'b0;
			if ($urandom_range(6) == 0) begin
				send_noise_item();
				done++;
			end else begin
				len = $urandom_range(1, 24);
				send_linked_chain(len);
				done += len;
			end
			if (chain_state == CHAIN_EMPTY && $urandom_range(5) == 0) begin
				case ($urandom_range(4))
					0: t = '0;
					1: t = '1;
					2: t = tol_t'($urandom_range(1, 200));
					default: t = tol_t'($urandom);
				endcase
				write_tolerance(t);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_chain_ends();
		test_endpoint_links();
		test_fallback();
		test_extremes();
		test_back_pressure();
		test_random_chains();
		settle();
		if (errors == 0)
			$display("PASS segment_chain_orienter_unit");
		else
			$display("FAIL segment_chain_orienter_unit");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout, %0d results still expected", oriented_due.size());
		$display("FAIL segment_chain_orienter_unit");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/scoru_pkg.sv
rtl/scoru_dist.sv
rtl/segment_chain_orienter_unit.sv
sim/segment_chain_orienter_unit_tb.sv
